// ----- sv/hcvim_pkg.sv -----
// ----------------------------------------------------------------------------
// hcvim_pkg
// Shared constants and register indexes for the hex cell vertex index map.
// ----------------------------------------------------------------------------
package hcvim_pkg;

    // default widths of ids and cell counts
    localparam int ID_WIDTH_DEF  = 32;
    localparam int DIM_WIDTH_DEF = 16;

    // configuration register indexes
    localparam logic [1:0] REG_VERTEX_BASE = 2'd0;
    localparam logic [1:0] REG_J_CELLS     = 2'd1;
    localparam logic [1:0] REG_K_CELLS     = 2'd2;

    // lookup kinds
    localparam logic KIND_CORNER_TO_VERTEX = 1'b0;
    localparam logic KIND_VERTEX_TO_CORNER = 1'b1;

    // cycles from an accepted item to its result strobe
    function automatic int latency(input int id_width);
        return 2 * id_width + 8;
    endfunction

endpackage

// ----- sv/hcvim_div.sv -----
// ----------------------------------------------------------------------------
// hcvim_div
// Restoring divider, one quotient bit per pipeline stage, with a sideband
// vector that travels with each item. The caller must hold the divisor steady
// while items are in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hcvim_div
    import hcvim_pkg::*;
#(
    parameter int ID_WIDTH  = ID_WIDTH_DEF,
    parameter int DIM_WIDTH = DIM_WIDTH_DEF,
    parameter int SB_WIDTH  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [ID_WIDTH-1:0]  i_num,
    input  logic [DIM_WIDTH-1:0] i_den,
    input  logic [SB_WIDTH-1:0]  i_sb,
    output logic                 o_vld,
    output logic [ID_WIDTH-1:0]  o_quo,
    output logic [DIM_WIDTH-1:0] o_rem,
    output logic [SB_WIDTH-1:0]  o_sb
);

    logic                 r_vld [ID_WIDTH];
    logic [ID_WIDTH-1:0]  r_x   [ID_WIDTH];
    logic [DIM_WIDTH-1:0] r_rem [ID_WIDTH];
    logic [SB_WIDTH-1:0]  r_sb  [ID_WIDTH];

    genvar s;
    generate
        for (s = 0; s < ID_WIDTH; s++) begin : g_stage
            logic                 src_vld;
            logic [ID_WIDTH-1:0]  src_x;
            logic [DIM_WIDTH-1:0] src_rem;
            logic [SB_WIDTH-1:0]  src_sb;
            logic [DIM_WIDTH:0]   trial;
            logic                 ge;
            logic [DIM_WIDTH:0]   diff;

            if (s == 0) begin : g_first
                assign src_vld = i_vld;
                assign src_x   = i_num;
                assign src_rem = '0;
                assign src_sb  = i_sb;
            end else begin : g_next
                assign src_vld = r_vld[s-1];
                assign src_x   = r_x[s-1];
                assign src_rem = r_rem[s-1];
                assign src_sb  = r_sb[s-1];
            end

            // shift in the next dividend bit, subtract if it fits
            assign trial = {src_rem, src_x[ID_WIDTH-1]};
            assign ge    = trial >= {1'b0, i_den};
            assign diff  = trial - {1'b0, i_den};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= src_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_x[s]   <= {src_x[ID_WIDTH-2:0], ge};
                r_rem[s] <= ge ? diff[DIM_WIDTH-1:0] : trial[DIM_WIDTH-1:0];
                r_sb[s]  <= src_sb;
            end
        end
    endgenerate

    assign o_vld = r_vld[ID_WIDTH-1];
    assign o_quo = r_x[ID_WIDTH-1];
    assign o_rem = r_rem[ID_WIDTH-1];
    assign o_sb  = r_sb[ID_WIDTH-1];

endmodule

// ----- sv/hex_cell_vertex_index_map_unit.sv -----
// ----------------------------------------------------------------------------
// hex_cell_vertex_index_map_unit
// Pipeline from start to o_res_vld: two bit-per-stage dividers followed by
// eight arithmetic stages.
// Throughput: one item per cycle; busy is high only during reset, results
// cannot be stalled.
// Reset (synchronous, active low) drops all items in flight and sets
// vertex_base to 0 and both cell counts to 1.
// ----------------------------------------------------------------------------
module hex_cell_vertex_index_map_unit
    import hcvim_pkg::*;
#(
    parameter int ID_WIDTH  = ID_WIDTH_DEF,
    parameter int DIM_WIDTH = DIM_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [ID_WIDTH-1:0] i_cfg_data,
    // command
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [ID_WIDTH-1:0] i_cell_id,
    input  logic [2:0]          i_corner_in,
    input  logic [ID_WIDTH-1:0] i_vertex_in,
    // result
    output logic                o_res_vld,
    output logic [ID_WIDTH-1:0] o_vertex_out,
    output logic [2:0]          o_corner_out,
    output logic                o_valid_res
);

    localparam int XW  = ID_WIDTH + 2 * DIM_WIDTH + 3;
    localparam int PW  = 2 * DIM_WIDTH + 2;
    localparam int SB1 = 1 + 3 + ID_WIDTH;
    localparam int SB2 = SB1 + DIM_WIDTH;

    // ---------------- configuration registers ----------------
    logic [ID_WIDTH-1:0]  r_vbase;
    logic [DIM_WIDTH-1:0] r_jc, r_kc;
    logic [DIM_WIDTH-1:0] n_cnt;
    logic [DIM_WIDTH:0]   r_jv, r_kv;
    logic [PW-1:0]        r_jkv, r_jkvkv;

    // a zero count is stored as one
    assign n_cnt = (i_cfg_data[DIM_WIDTH-1:0] == '0) ? DIM_WIDTH'(1)
                                                     : i_cfg_data[DIM_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbase <= '0;
            r_jc    <= DIM_WIDTH'(1);
            r_kc    <= DIM_WIDTH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VERTEX_BASE: r_vbase <= i_cfg_data;
                REG_J_CELLS:     r_jc    <= n_cnt;
                REG_K_CELLS:     r_kc    <= n_cnt;
                default: ;
            endcase
        end
    end

    // derived strides, settled long before an item reaches them
    always_ff @(posedge i_clk) begin
        r_jv    <= {1'b0, r_jc} + (DIM_WIDTH+1)'(1);
        r_kv    <= {1'b0, r_kc} + (DIM_WIDTH+1)'(1);
        r_jkv   <= PW'(r_jv) * PW'(r_kv);
        r_jkvkv <= r_jkv + PW'(r_kv);
    end

    // items are taken in every cycle outside reset
    assign busy = !i_rst_n;

    // ---------------- divider chain: k, then j and i ----------------
    logic                 d1_vld, d2_vld;
    logic [ID_WIDTH-1:0]  d1_quo, d2_quo;
    logic [DIM_WIDTH-1:0] d1_rem, d2_rem;
    logic [SB1-1:0]       d1_sb;
    logic [SB2-1:0]       d2_sb;

    hcvim_div #(.ID_WIDTH(ID_WIDTH), .DIM_WIDTH(DIM_WIDTH), .SB_WIDTH(SB1)) u_div_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_num   (i_cell_id),
        .i_den   (r_kc),
        .i_sb    ({i_kind, i_corner_in, i_vertex_in}),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_sb    (d1_sb)
    );

    hcvim_div #(.ID_WIDTH(ID_WIDTH), .DIM_WIDTH(DIM_WIDTH), .SB_WIDTH(SB2)) u_div_j (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d1_vld),
        .i_num   (d1_quo),
        .i_den   (r_jc),
        .i_sb    ({d1_sb, d1_rem}),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_sb    (d2_sb)
    );

    logic                 s_kind;
    logic [2:0]           s_corner;
    logic [ID_WIDTH-1:0]  s_vin;
    logic [DIM_WIDTH-1:0] s_k;
    assign {s_kind, s_corner, s_vin, s_k} = d2_sb;

    // ---------------- arithmetic stages ----------------
    logic [7:0]           r_vld;
    logic                 r_kind   [7];
    logic [2:0]           r_corner [5];
    logic [ID_WIDTH-1:0]  r_vin    [5];
    logic [DIM_WIDTH-1:0] r_k      [3];
    logic [DIM_WIDTH-1:0] r_j1;
    logic [ID_WIDTH+DIM_WIDTH:0] r_m1;
    logic [ID_WIDTH-1:0]  r_a1;
    logic [ID_WIDTH+DIM_WIDTH:0] r_m2;
    logic [ID_WIDTH-1:0]  r_a2, r_first;
    logic                 r_ovf [2:5];
    logic [ID_WIDTH-1:0]  r_vo6, r_vo7, r_d6, r_d7;
    logic                 r_ok6, r_ok7, r_dge7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], d2_vld};
        end
    end

    // sideband shift
    always_ff @(posedge i_clk) begin
        r_kind[0]   <= s_kind;
        r_corner[0] <= s_corner;
        r_vin[0]    <= s_vin;
        r_k[0]      <= s_k;
        for (int n = 1; n < 7; n++) r_kind[n] <= r_kind[n-1];
        for (int n = 1; n < 5; n++) begin
            r_corner[n] <= r_corner[n-1];
            r_vin[n]    <= r_vin[n-1];
        end
        for (int n = 1; n < 3; n++) r_k[n] <= r_k[n-1];
    end

    logic [ID_WIDTH:0]   n_a1, n_a2, n_a3;
    logic [XW-1:0]       n_sum;
    logic [PW-1:0]       n_off;
    logic [ID_WIDTH-1:0] n_d8;
    logic                n_kge;
    logic [1:0]          n_base;

    always_comb begin
        n_a1 = {1'b0, r_m1[ID_WIDTH-1:0]} + (ID_WIDTH+1)'(r_j1);
        n_a2 = {1'b0, r_m2[ID_WIDTH-1:0]} + (ID_WIDTH+1)'(r_k[2]);
        n_a3 = {1'b0, r_a2} + {1'b0, r_vbase};
        // corner offsets: low two bits pick the i/j face, bit 2 steps k
        case (r_corner[4][1:0])
            2'd0:    n_off = '0;
            2'd1:    n_off = r_jkv;
            2'd2:    n_off = r_jkvkv;
            default: n_off = PW'(r_kv);
        endcase
        n_sum  = XW'(r_first) + XW'(n_off) + XW'(r_corner[4][2]);
        n_kge  = {1'b0, r_d7} >= (ID_WIDTH+1)'(r_kv);
        n_d8   = n_kge ? r_d7 - ID_WIDTH'(r_kv) : r_d7;
        n_base = {r_dge7, n_kge};
    end

    always_ff @(posedge i_clk) begin
        // P1: i * (J+1)
        r_m1     <= d2_quo * r_jv;
        r_j1     <= d2_rem;
        // P2: + j
        r_ovf[2] <= (r_m1[ID_WIDTH+DIM_WIDTH:ID_WIDTH] != '0) | n_a1[ID_WIDTH];
        r_a1     <= n_a1[ID_WIDTH-1:0];
        // P3: * (K+1)
        r_m2     <= r_a1 * r_kv;
        r_ovf[3] <= r_ovf[2];
        // P4: + k
        r_ovf[4] <= r_ovf[3] | (r_m2[ID_WIDTH+DIM_WIDTH:ID_WIDTH] != '0) | n_a2[ID_WIDTH];
        r_a2     <= n_a2[ID_WIDTH-1:0];
        // P5: + base gives the first vertex
        r_ovf[5] <= r_ovf[4] | n_a3[ID_WIDTH];
        r_first  <= n_a3[ID_WIDTH-1:0];
        // P6: corner vertex, or distance from the first vertex
        if (r_kind[4] == KIND_CORNER_TO_VERTEX) begin
            r_ok6 <= !r_ovf[5] && (n_sum[XW-1:ID_WIDTH] == '0);
            r_vo6 <= n_sum[ID_WIDTH-1:0];
        end else begin
            r_ok6 <= !r_ovf[5] && (r_vin[4] >= r_first);
            r_vo6 <= '0;
        end
        r_d6     <= r_vin[4] - r_first;
        // P7: strip the i step
        r_ok7    <= r_ok6;
        r_vo7    <= r_vo6;
        r_dge7   <= XW'(r_d6) >= XW'(r_jkv);
        r_d7     <= (XW'(r_d6) >= XW'(r_jkv)) ? r_d6 - ID_WIDTH'(r_jkv) : r_d6;
        // P8: strip the j step and form the result
        if (r_kind[6] == KIND_CORNER_TO_VERTEX) begin
            o_valid_res  <= r_ok7;
            o_vertex_out <= r_ok7 ? r_vo7 : '0;
            o_corner_out <= '0;
        end else begin
            o_vertex_out <= '0;
            if (r_ok7 && n_d8 <= ID_WIDTH'(1)) begin
                o_valid_res <= 1'b1;
                case (n_base)
                    2'b00:   o_corner_out <= {n_d8[0], 2'd0};
                    2'b01:   o_corner_out <= {n_d8[0], 2'd3};
                    2'b10:   o_corner_out <= {n_d8[0], 2'd1};
                    default: o_corner_out <= {n_d8[0], 2'd2};
                endcase
            end else begin
                o_valid_res  <= 1'b0;
                o_corner_out <= '0;
            end
        end
    end

    assign o_res_vld = r_vld[7];

endmodule

// ----- sv/hcvim_checker.sv -----
// ----------------------------------------------------------------------------
// hcvim_checker
// Port-level checks on the hex cell vertex index map, bound to the top level.
// ----------------------------------------------------------------------------
module hcvim_checker
    import hcvim_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_res_vld,
    input logic [ID_WIDTH-1:0] o_vertex_out,
    input logic [2:0]          o_corner_out,
    input logic                o_valid_res
);

    localparam int LAT = latency(ID_WIDTH);

    // never stalls the sender
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // a result strobe follows an accepted item by the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> $past(start, LAT))
        else $error("result without matching item");

    // invalid results carry zero payload
    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && !o_valid_res) |-> (o_vertex_out == '0 && o_corner_out == '0))
        else $error("invalid result with payload");

    // only one of the two payload fields is used per item
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_vertex_out != '0) |-> (o_corner_out == '0))
        else $error("both payload fields set");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_vld)
        else $error("result after reset");

endmodule

bind hex_cell_vertex_index_map_unit hcvim_checker #(.ID_WIDTH(ID_WIDTH)) u_hcvim_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_vld    (o_res_vld),
    .o_vertex_out (o_vertex_out),
    .o_corner_out (o_corner_out),
    .o_valid_res  (o_valid_res)
);

// ----- tb/hex_cell_vertex_index_map_unit_test.sv -----
// ----------------------------------------------------------------------------
// hex_cell_vertex_index_map_unit_test
// Drives corner/vertex lookups into the hex cell vertex index map across
// several grid settings, predicts every result in the testbench and checks
// each result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_cell_vertex_index_map_unit_test;
    import hcvim_pkg::*;

    localparam int                 IDW      = ID_WIDTH_DEF;
    localparam longint unsigned    ID_MAX   = 64'hFFFF_FFFF;
    localparam int                 LAT      = latency(ID_WIDTH_DEF);
    localparam int                 WD_LIMIT = 4000;

    typedef struct {
        logic           kind;
        logic [IDW-1:0] cell_id;
        logic [2:0]     corner;
        logic [IDW-1:0] vin;
    } lookup_item_t;

    typedef struct {
        logic [IDW-1:0] vertex;
        logic [2:0]     corner;
        logic           valid;
    } lookup_result_t;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [1:0]     i_cfg_idx;
    logic [IDW-1:0] i_cfg_data;
    logic           start;
    logic           busy;
    logic           i_kind;
    logic [IDW-1:0] i_cell_id;
    logic [2:0]     i_corner_in;
    logic [IDW-1:0] i_vertex_in;
    logic           o_res_vld;
    logic [IDW-1:0] o_vertex_out;
    logic [2:0]     o_corner_out;
    logic           o_valid_res;

    hex_cell_vertex_index_map_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_cell_id    (i_cell_id),
        .i_corner_in  (i_corner_in),
        .i_vertex_in  (i_vertex_in),
        .o_res_vld    (o_res_vld),
        .o_vertex_out (o_vertex_out),
        .o_corner_out (o_corner_out),
        .o_valid_res  (o_valid_res)
    );

    // grid settings as written to the block, counts cut to their low 16 bits
    longint unsigned grid_base;
    longint unsigned grid_j;
    longint unsigned grid_k;

    lookup_item_t   pending_items[$];
    lookup_result_t expected_maps[$];
    bit             took_item;
    bit             no_gaps;
    bit             failed;
    int             quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned add_id(input longint unsigned a,
                                               input longint unsigned b,
                                               inout bit ovf);
        if (a > ID_MAX || b > ID_MAX - a) begin
            ovf = 1'b1;
            return 0;
        end
        return a + b;
    endfunction

    function automatic longint unsigned mul_id(input longint unsigned a,
                                               input longint unsigned b,
                                               inout bit ovf);
        if (a != 0 && b > ID_MAX / a) begin
            ovf = 1'b1;
            return 0;
        end
        return a * b;
    endfunction

    // expected lookup result for one item under the current grid
    function automatic lookup_result_t map_lookup(input lookup_item_t it);
        lookup_result_t  r;
        longint unsigned jc, kc, kv, jkv, ci, cj, ck, first, off, d, sel;
        bit              ovf;
        ovf   = 1'b0;
        r.vertex = '0;
        r.corner = '0;
        r.valid  = 1'b0;
        jc  = (grid_j != 0) ? grid_j : 1;
        kc  = (grid_k != 0) ? grid_k : 1;
        kv  = kc + 1;
        jkv = (jc + 1) * kv;
        ck  = longint'(it.cell_id) % kc;
        cj  = (longint'(it.cell_id) / kc) % jc;
        ci  = longint'(it.cell_id) / (jc * kc);
        first = mul_id(ci, jc + 1, ovf);
        first = add_id(first, cj, ovf);
        first = mul_id(first, kv, ovf);
        first = add_id(first, ck, ovf);
        first = add_id(first, grid_base, ovf);
        if (it.kind == KIND_CORNER_TO_VERTEX) begin
            // corners 0..3 lie at k, 4..7 at k+1
            case (it.corner)
                3'd0:    off = 0;
                3'd1:    off = jkv;
                3'd2:    off = jkv + kv;
                3'd3:    off = kv;
                3'd4:    off = 1;
                3'd5:    off = jkv + 1;
                3'd6:    off = jkv + kv + 1;
                default: off = kv + 1;
            endcase
            off = add_id(first, off, ovf);
            if (!ovf) begin
                r.vertex = off[IDW-1:0];
                r.valid  = 1'b1;
            end
        end else if (!ovf && longint'(it.vin) >= first) begin
            d = longint'(it.vin) - first;
            if (d >= jkv) begin
                d -= jkv;
                if (d >= kv) begin
                    d -= kv;
                    sel = 2;
                end else begin
                    sel = 1;
                end
            end else if (d >= kv) begin
                d -= kv;
                sel = 3;
            end else begin
                sel = 0;
            end
            if (d <= 1) begin
                sel      = sel + 4 * d;
                r.corner = sel[2:0];
                r.valid  = 1'b1;
            end
        end
        return r;
    endfunction

    // random item, mostly cells inside a modest grid and real corner vertices
    function automatic lookup_item_t random_item();
        lookup_item_t    it;
        lookup_item_t    probe;
        lookup_result_t  hit;
        longint unsigned span, jc, kc;
        int              mode;
        jc   = (grid_j != 0) ? grid_j : 1;
        kc   = (grid_k != 0) ? grid_k : 1;
        span = jc * kc * 8;
        if (span > ID_MAX)
            span = ID_MAX;
        mode = $urandom_range(9);
        if (mode < 6)
            it.cell_id = $urandom_range(span[31:0], 0);
        else if (mode < 9)
            it.cell_id = $urandom;
        else
            it.cell_id = $urandom_range(1) ? '1 : '0;
        it.kind   = $urandom_range(1);
        it.corner = $urandom_range(7);
        it.vin    = $urandom;
        if (it.kind == KIND_VERTEX_TO_CORNER) begin
            probe        = it;
            probe.kind   = KIND_CORNER_TO_VERTEX;
            hit          = map_lookup(probe);
            mode         = $urandom_range(9);
            if (hit.valid && mode < 7)
                it.vin = hit.vertex;
            else if (hit.valid && mode < 9)
                it.vin = hit.vertex + $urandom_range(4) - 2;
        end
        return it;
    endfunction

    function automatic lookup_item_t make_item(input logic k, input logic [IDW-1:0] c,
                                               input logic [2:0] cr,
                                               input logic [IDW-1:0] v);
        lookup_item_t it;
        it.kind    = k;
        it.cell_id = c;
        it.corner  = cr;
        it.vin     = v;
        return it;
    endfunction

    // driver: fields change on the falling edge
    always @(negedge i_clk) begin : drive_items
        if (took_item)
            void'(pending_items.pop_front());
        if (i_rst_n && pending_items.size() > 0 &&
            (no_gaps || $urandom_range(99) >= 22)) begin
            start       <= 1'b1;
            i_kind      <= pending_items[0].kind;
            i_cell_id   <= pending_items[0].cell_id;
            i_corner_in <= pending_items[0].corner;
            i_vertex_in <= pending_items[0].vin;
        end else begin
            start       <= 1'b0;
            i_kind      <= $urandom_range(1);
            i_cell_id   <= $urandom;
            i_corner_in <= $urandom_range(7);
            i_vertex_in <= $urandom;
        end
    end

    // monitor: accept items, check results, watch for a hang
    always @(posedge i_clk) begin : watch_results
        lookup_item_t   it;
        lookup_result_t want;
        took_item <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) begin
                it.kind    = i_kind;
                it.cell_id = i_cell_id;
                it.corner  = i_corner_in;
                it.vin     = i_vertex_in;
                expected_maps.push_back(map_lookup(it));
            end
            if (o_res_vld) begin
                if (expected_maps.size() == 0) begin
                    $display("%0t: result with nothing pending: vertex %h corner %0d valid %b",
                             $time, o_vertex_out, o_corner_out, o_valid_res);
                    failed = 1'b1;
                end else begin
                    want = expected_maps.pop_front();
                    if (o_vertex_out !== want.vertex) begin
                        $display("%0t: vertex_out expected %h actual %h",
                                 $time, want.vertex, o_vertex_out);
                        failed = 1'b1;
                    end
                    if (o_corner_out !== want.corner) begin
                        $display("%0t: corner_out expected %0d actual %0d",
                                 $time, want.corner, o_corner_out);
                        failed = 1'b1;
                    end
                    if (o_valid_res !== want.valid) begin
                        $display("%0t: valid_res expected %b actual %b",
                                 $time, want.valid, o_valid_res);
                        failed = 1'b1;
                    end
                end
            end
            if ((start && !busy) || o_res_vld)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // config writes happen only with the pipe drained
    task automatic write_reg(input logic [1:0] idx, input logic [IDW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_VERTEX_BASE: grid_base = data;
            REG_J_CELLS:     grid_j    = data[15:0];
            default:         grid_k    = data[15:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || start || expected_maps.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic run_grid(input logic [IDW-1:0] base, input logic [IDW-1:0] jd,
                            input logic [IDW-1:0] kd, input int count, input bit steady);
        drain();
        write_reg(REG_VERTEX_BASE, base);
        write_reg(REG_J_CELLS, jd);
        write_reg(REG_K_CELLS, kd);
        @(posedge i_clk);
        no_gaps = steady;
        repeat (count) pending_items.push_back(random_item());
    endtask

    // stimulus
    initial begin : stimulus
        lookup_item_t   it;
        lookup_result_t hit;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_VERTEX_BASE;
        i_cfg_data = '0;
        start      = 1'b0;
        i_kind     = KIND_CORNER_TO_VERTEX;
        i_cell_id  = '0;
        i_corner_in = '0;
        i_vertex_in = '0;
        took_item  = 1'b0;
        no_gaps    = 1'b0;
        failed     = 1'b0;
        quiet_cycles = 0;
        grid_base  = 0;
        grid_j     = 1;
        grid_k     = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every corner both ways, misses, extremes, overflow
        write_reg(REG_VERTEX_BASE, 32'd1000);
        write_reg(REG_J_CELLS, 32'd2);
        write_reg(REG_K_CELLS, 32'd3);
        @(posedge i_clk);
        for (int c = 0; c < 8; c++) begin
            it = make_item(KIND_CORNER_TO_VERTEX, 32'd5, c[2:0], '0);
            pending_items.push_back(it);
            hit = map_lookup(it);
            pending_items.push_back(make_item(KIND_VERTEX_TO_CORNER, 32'd5, 3'd0, hit.vertex));
        end
        hit = map_lookup(make_item(KIND_CORNER_TO_VERTEX, 32'd5, 3'd0, '0));
        pending_items.push_back(make_item(KIND_VERTEX_TO_CORNER, 32'd5, 3'd7, '0));
        pending_items.push_back(make_item(KIND_VERTEX_TO_CORNER, 32'd5, 3'd0,
                                          hit.vertex + 2));
        pending_items.push_back(make_item(KIND_VERTEX_TO_CORNER, 32'd5, 3'd0, '1));
        pending_items.push_back(make_item(KIND_CORNER_TO_VERTEX, '1, 3'd7, '1));
        pending_items.push_back(make_item(KIND_VERTEX_TO_CORNER, '1, 3'd0, '1));
        pending_items.push_back(make_item(KIND_CORNER_TO_VERTEX, '0, 3'd7, '0));
        repeat (150) pending_items.push_back(random_item());

        // zero counts act as one; extremes; near-overflow base without gaps
        run_grid(32'd0, 32'd0, 32'd0, 180, 1'b0);
        run_grid('1, 32'd65535, 32'd65535, 180, 1'b0);
        run_grid(32'hFFFF_FF00, 32'd1, 32'd1, 200, 1'b1);
        // upper data bits of a count register are dropped
        run_grid($urandom, {16'hABCD, 16'($urandom_range(300, 1))},
                 32'($urandom_range(300, 1)), 200, 1'b0);
        run_grid(32'd0, 32'd65535, 32'd1, 150, 1'b0);
        run_grid(32'd7, 32'd3, 32'hFFFF_FFFF, 100, 1'b0);

        drain();
        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
